[sv/fap_pkg.sv]
// fap_pkg: shared constants and codes of the frame allocator with pinning.
// No dependencies; used through scoped names by the top level.
package fap_pkg;

   localparam int MAX_FRAMES_DEFAULT = 64;
   localparam int PAGE_BITS_DEFAULT  = 20;

   localparam int OPCODE_W      = 3;
   localparam int PAGE_W        = 20;
   localparam int INDEX_W       = 8;
   localparam int STATUS_W      = 2;
   localparam int FRAME_OUT_W   = 6;
   localparam int FAULT_W       = 32;
   localparam int ALLOC_TOTAL_W = 7;
   localparam int FRAME_COUNT_W = 7;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int FRAME_COUNT_RESET = 64;

   // register index, taken from csr_paddr[2]
   localparam logic REG_FRAME_COUNT = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOCATE = 3'd0,
      OP_FREE     = 3'd1,
      OP_PIN      = 3'd2,
      OP_UNPIN    = 3'd3,
      OP_QUERY    = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_FRAME  = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

endpackage

[sv/fap_free_queue.sv]
// fap_free_queue: storage of the FIFO free list, one write and one registered read port.
// Entries never written since reset or reconfiguration read as their own position.
// Same-cycle write to the read address is forwarded. No package dependencies.
module fap_free_queue #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_FRAMES)-1:0] wr_addr,
   input  logic [$clog2(MAX_FRAMES)-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_FRAMES)-1:0] rd_addr,
   output logic [$clog2(MAX_FRAMES)-1:0] rd_data
);

   localparam int IW = $clog2(MAX_FRAMES);

   logic [IW-1:0]         mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] written_ff, written_in;
   logic [IW-1:0]         mem_q_ff, rd_addr_ff, fwd_data_ff;
   logic                  fwd_ff, written_q_ff;

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
      if (clear) begin
         written_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff     <= mem[rd_addr];
         rd_addr_ff   <= rd_addr;
         fwd_ff       <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff  <= wr_data;
         written_q_ff <= written_in[rd_addr];
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (written_q_ff ? mem_q_ff : rd_addr_ff);

endmodule

[sv/fap_owner_ram.sv]
// fap_owner_ram: owner page table, one write and one registered read port.
// Same-cycle write to the read address is forwarded. No package dependencies.
module fap_owner_ram #(
   parameter int MAX_FRAMES = 64,
   parameter int PAGE_BITS  = 20
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_FRAMES)-1:0] wr_addr,
   input  logic [PAGE_BITS-1:0]          wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_FRAMES)-1:0] rd_addr,
   output logic [PAGE_BITS-1:0]          rd_data
);

   logic [PAGE_BITS-1:0] mem [MAX_FRAMES];
   logic [PAGE_BITS-1:0] mem_q_ff, fwd_data_ff;
   logic                 fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : mem_q_ff;

endmodule

[sv/frame_allocator_with_pinning.sv]
// frame_allocator_with_pinning: top level of the physical frame allocator.
// Depends on fap_pkg, fap_free_queue and fap_owner_ram.
//
// Usage:
//   req_* carries one operation per transfer (allocate, free, pin, unpin,
//   query); rsp_* returns exactly one result per request, in order.
//   csr_* is an APB-style port holding frame_count at address 0. Writing it
//   restores the whole allocator to its reset state with the new count;
//   write it only while no request is in flight.
// Pipeline and throughput:
//   A request is registered on acceptance together with its free-list and
//   owner-table reads, is executed once the response register is free or
//   drains, and lands in the response register that drives rsp_tvalid.
//   One request per cycle is sustained with rsp_tready high; the bound is
//   the head pointer, allocation-bit and lowest-victim encoder update.
// Reset:
//   Synchronous. The free list holds frames 0 upward, fault and in-use
//   counts clear, frame_count is 64; no clearing pass, all usable at once.
// Stalls:
//   With rsp_tready low one result waits in the response register and one
//   more request is held in the execute register; req_tready then drops.
module frame_allocator_with_pinning #(
   parameter int MAX_FRAMES = fap_pkg::MAX_FRAMES_DEFAULT,
   parameter int PAGE_BITS  = fap_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [19:0] page_number, [27:20] frame_index, [31:28] zero
   input  logic [fap_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] opcode
   input  logic [fap_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [7:2] frame_out, [8] from_victim, [9] entry_allocated,
   // [10] entry_pinned, [30:11] entry_owner, [62:31] fault_total,
   // [69:63] allocated_total, [71:70] zero
   output logic [fap_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fap_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fap_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fap_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int IW = $clog2(MAX_FRAMES);
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int SW = CW + 1;
   localparam int XW = (CW > fap_pkg::INDEX_W) ? CW : fap_pkg::INDEX_W;
   localparam int FW = (CW > fap_pkg::FRAME_COUNT_W) ? CW : fap_pkg::FRAME_COUNT_W;
   localparam int NEFF_RESET_INT = (fap_pkg::FRAME_COUNT_RESET > MAX_FRAMES) ?
                                   MAX_FRAMES : fap_pkg::FRAME_COUNT_RESET;
   localparam logic [CW-1:0] NEFF_RESET = CW'(NEFF_RESET_INT);
   localparam logic [IW-1:0] LAST_FRAME = IW'(MAX_FRAMES - 1);

   // configuration
   logic                               cfg_wr;
   logic [fap_pkg::FRAME_COUNT_W-1:0]  fc_new;
   logic [CW-1:0]                      neff_new;
   logic [fap_pkg::FRAME_COUNT_W-1:0]  frame_count_ff, frame_count_in;
   logic [CW-1:0]                      neff_ff, neff_in;

   // handshake
   logic accept, exec_fire;
   logic exec_valid_ff, exec_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // execute register
   logic [fap_pkg::OPCODE_W-1:0] op_ff;
   logic [fap_pkg::PAGE_W-1:0]   page_ff;
   logic [fap_pkg::INDEX_W-1:0]  idx_ff;

   // allocator state
   logic [IW-1:0]                head_ff, head_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [MAX_FRAMES-1:0]        alloc_ff, alloc_in;
   logic [MAX_FRAMES-1:0]        pin_ff, pin_in;
   logic [fap_pkg::FAULT_W-1:0]  fault_ff, fault_in;
   logic [CW-1:0]                acnt_ff, acnt_in;

   // execute logic
   logic [IW-1:0]         idx_a, tail, q_head_data, victim_idx;
   logic [SW-1:0]         tail_sum;
   logic                  idx_ok, victim_found;
   logic [MAX_FRAMES-1:0] range_mask, victim_mask;
   logic [PAGE_BITS-1:0]  own_rd_data;
   logic                  q_wr_en, own_wr_en;

   fap_pkg::status_type   res_status;
   logic [IW-1:0]         res_frame;
   logic                  res_victim, res_ealloc, res_epin;
   logic [PAGE_BITS-1:0]  res_eowner;

   // response register
   fap_pkg::status_type                   st_ff;
   logic [fap_pkg::FRAME_OUT_W-1:0]       frame_ff;
   logic                                  victim_ff, ealloc_ff, epin_ff;
   logic [fap_pkg::PAGE_W-1:0]            eowner_ff;
   logic [fap_pkg::FAULT_W-1:0]           fault_out_ff;
   logic [fap_pkg::ALLOC_TOTAL_W-1:0]     atot_ff;

   // ---------------- configuration port ----------------
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == fap_pkg::REG_FRAME_COUNT);
   assign fc_new = csr_pwdata[fap_pkg::FRAME_COUNT_W-1:0];

   always_comb begin
      if (fc_new == '0) begin
         neff_new = CW'(1);
      end else if (FW'(fc_new) > FW'(MAX_FRAMES)) begin
         neff_new = CW'(MAX_FRAMES);
      end else begin
         neff_new = CW'(fc_new);
      end
      frame_count_in = cfg_wr ? fc_new : frame_count_ff;
      neff_in        = cfg_wr ? neff_new : neff_ff;
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == fap_pkg::REG_FRAME_COUNT) ?
                       fap_pkg::CSR_DATA_W'(frame_count_ff) : '0;

   // ---------------- handshake ----------------
   assign exec_fire  = exec_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!exec_valid_ff || exec_fire);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (accept) begin
         exec_valid_in = 1'b1;
      end else if (exec_fire) begin
         exec_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- memories ----------------
   fap_free_queue #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_free_queue (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_wr),
      .wr_en   (q_wr_en),
      .wr_addr (tail),
      .wr_data (idx_a),
      .rd_en   (accept),
      .rd_addr (head_in),
      .rd_data (q_head_data)
   );

   fap_owner_ram #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (q_head_data),
      .wr_data (PAGE_BITS'(page_ff)),
      .rd_en   (accept),
      .rd_addr (IW'(req_tdata[27:20])),
      .rd_data (own_rd_data)
   );

   // ---------------- execute ----------------
   assign idx_a    = IW'(idx_ff);
   assign idx_ok   = XW'(idx_ff) < XW'(neff_ff);
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail     = (tail_sum >= SW'(MAX_FRAMES)) ? IW'(tail_sum - SW'(MAX_FRAMES)) :
                                                      IW'(tail_sum);

   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         range_mask[i] = CW'(i) < neff_ff;
      end
      victim_mask  = alloc_ff & ~pin_ff & range_mask;
      victim_found = |victim_mask;
      victim_idx   = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (victim_mask[i]) begin
            victim_idx = IW'(i);
         end
      end
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      alloc_in   = alloc_ff;
      pin_in     = pin_ff;
      fault_in   = fault_ff;
      acnt_in    = acnt_ff;
      q_wr_en    = 1'b0;
      own_wr_en  = 1'b0;
      res_status = fap_pkg::ST_OK;
      res_frame  = '0;
      res_victim = 1'b0;
      res_ealloc = 1'b0;
      res_epin   = 1'b0;
      res_eowner = '0;
      if (exec_fire) begin
         if (op_ff == fap_pkg::OP_ALLOCATE) begin
            fault_in = fault_ff + 1'b1;
            if (count_ff != '0) begin
               head_in                = (head_ff == LAST_FRAME) ? '0 : head_ff + 1'b1;
               count_in               = count_ff - 1'b1;
               alloc_in[q_head_data]  = 1'b1;
               acnt_in                = acnt_ff + 1'b1;
               own_wr_en              = 1'b1;
               res_frame              = q_head_data;
            end else if (victim_found) begin
               res_frame  = victim_idx;
               res_victim = 1'b1;
            end else begin
               res_status = fap_pkg::ST_NO_FRAME;
            end
         end else if (op_ff inside {fap_pkg::OP_FREE, fap_pkg::OP_PIN,
                                    fap_pkg::OP_UNPIN, fap_pkg::OP_QUERY}) begin
            if (!idx_ok) begin
               res_status = fap_pkg::ST_BAD_INDEX;
            end else begin
               case (op_ff)
                  fap_pkg::OP_FREE: begin
                     if (alloc_ff[idx_a]) begin
                        alloc_in[idx_a] = 1'b0;
                        pin_in[idx_a]   = 1'b0;
                        acnt_in         = acnt_ff - 1'b1;
                        count_in        = count_ff + 1'b1;
                        q_wr_en         = 1'b1;
                     end
                  end
                  fap_pkg::OP_PIN: begin
                     pin_in[idx_a] = 1'b1;
                  end
                  fap_pkg::OP_UNPIN: begin
                     pin_in[idx_a] = 1'b0;
                  end
                  fap_pkg::OP_QUERY: begin
                     res_frame  = idx_a;
                     res_ealloc = alloc_ff[idx_a];
                     res_epin   = pin_ff[idx_a];
                     res_eowner = alloc_ff[idx_a] ? own_rd_data : '0;
                  end
                  default: ;
               endcase
            end
         end
      end
      if (cfg_wr) begin
         head_in  = '0;
         count_in = neff_new;
         alloc_in = '0;
         pin_in   = '0;
         fault_in = '0;
         acnt_in  = '0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= fap_pkg::FRAME_COUNT_W'(fap_pkg::FRAME_COUNT_RESET);
         neff_ff        <= NEFF_RESET;
         exec_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         head_ff        <= '0;
         count_ff       <= NEFF_RESET;
         alloc_ff       <= '0;
         pin_ff         <= '0;
         fault_ff       <= '0;
         acnt_ff        <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         neff_ff        <= neff_in;
         exec_valid_ff  <= exec_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         alloc_ff       <= alloc_in;
         pin_ff         <= pin_in;
         fault_ff       <= fault_in;
         acnt_ff        <= acnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser[fap_pkg::OPCODE_W-1:0];
         page_ff <= req_tdata[19:0];
         idx_ff  <= req_tdata[27:20];
      end
      if (exec_fire) begin
         st_ff        <= res_status;
         frame_ff     <= fap_pkg::FRAME_OUT_W'(res_frame);
         victim_ff    <= res_victim;
         ealloc_ff    <= res_ealloc;
         epin_ff      <= res_epin;
         eowner_ff    <= fap_pkg::PAGE_W'(res_eowner);
         fault_out_ff <= fault_in;
         atot_ff      <= fap_pkg::ALLOC_TOTAL_W'(acnt_in);
      end
   end

   assign rsp_tdata = {2'b00, atot_ff, fault_out_ff, eowner_ff, epin_ff, ealloc_ff,
                       victim_ff, frame_ff, st_ff};

   // ---------------- assertions ----------------
   a_acnt_matches_bits: assert property (@(posedge clock) disable iff (reset)
      acnt_ff == CW'($countones(alloc_ff)))
      else $error("allocated counter out of step with allocation bits");

   a_frames_conserved: assert property (@(posedge clock) disable iff (reset)
      SW'(count_ff) + SW'(acnt_ff) == SW'(neff_ff))
      else $error("free plus allocated frames differ from frame count");

   a_flags_in_range: assert property (@(posedge clock) disable iff (reset)
      ((alloc_ff | pin_ff) & ~range_mask) == '0)
      else $error("flag set on a frame beyond the frame count");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for frame_allocator_with_pinning.
// Replays each operation through an in-bench allocator that mirrors the free
// list, frame table and counters. Depends on fap_pkg and the DUT only.
module tb_top;

   localparam int FRAMES      = fap_pkg::MAX_FRAMES_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASES      = 10;
   localparam logic [fap_pkg::OPCODE_W-1:0] OPCODE_TOP = '1;

   typedef struct packed {
      logic [fap_pkg::OPCODE_W-1:0] op;
      logic [fap_pkg::PAGE_W-1:0]   page;
      logic [fap_pkg::INDEX_W-1:0]  index;
   } frame_op_type;

   typedef struct packed {
      fap_pkg::status_type                 status;
      logic [fap_pkg::FRAME_OUT_W-1:0]     frame;
      logic                                victim;
      logic                                owned;
      logic                                pinned;
      logic [fap_pkg::PAGE_W-1:0]          owner;
      logic [fap_pkg::FAULT_W-1:0]         faults;
      logic [fap_pkg::ALLOC_TOTAL_W-1:0]   in_use;
   } frame_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // [19:0] page_number, [27:20] frame_index, [31:28] zero
   logic [fap_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // [2:0] opcode
   logic [fap_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // [1:0] status, [7:2] frame_out, [8] from_victim, [9] entry_allocated,
   // [10] entry_pinned, [30:11] entry_owner, [62:31] fault_total,
   // [69:63] allocated_total, [71:70] zero
   logic [fap_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [fap_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [fap_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [fap_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   frame_allocator_with_pinning dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // mirrored allocator state
   logic [fap_pkg::FRAME_OUT_W-1:0]   ring_frames [FRAMES];
   logic [fap_pkg::FRAME_OUT_W-1:0]   ring_head;
   logic [fap_pkg::ALLOC_TOTAL_W-1:0] ring_fill;
   logic                              frame_owned [FRAMES];
   logic                              frame_pinned [FRAMES];
   logic [fap_pkg::PAGE_W-1:0]        frame_owner [FRAMES];
   logic [fap_pkg::FAULT_W-1:0]       fault_tally;
   logic [fap_pkg::ALLOC_TOTAL_W-1:0] owned_tally;
   int                                active_frames;

   frame_op_type    op_backlog[$];
   frame_reply_type due_replies[$];
   int              mismatches = 0;
   int              send_gap_pct = 0;
   int              stall_pct = 0;
   int              hold_requests = 0;
   int              cycles = 0;

   function automatic void restart_allocator(logic [fap_pkg::FRAME_COUNT_W-1:0] count);
      active_frames = (count == 0) ? 1 : ((count > FRAMES) ? FRAMES : int'(count));
      for (int i = 0; i < FRAMES; i++) begin
         ring_frames[i]  = fap_pkg::FRAME_OUT_W'(i);
         frame_owned[i]  = 1'b0;
         frame_pinned[i] = 1'b0;
         frame_owner[i]  = '0;
      end
      ring_head   = '0;
      ring_fill   = fap_pkg::ALLOC_TOTAL_W'(active_frames);
      fault_tally = '0;
      owned_tally = '0;
   endfunction

   function automatic frame_reply_type apply_frame_op(frame_op_type r);
      frame_reply_type x;
      logic [fap_pkg::FRAME_OUT_W-1:0] f;
      bit found;
      x = '0;
      x.status = fap_pkg::ST_OK;
      if (r.op == fap_pkg::OP_ALLOCATE) begin
         fault_tally++;
         if (ring_fill != 0) begin
            f = ring_frames[ring_head];
            ring_head++;
            ring_fill--;
            frame_owned[f] = 1'b1;
            frame_owner[f] = r.page;
            owned_tally++;
            x.frame = f;
         end else begin
            found = 0;
            for (int i = 0; i < active_frames; i++)
               if (!found && frame_owned[i] && !frame_pinned[i]) begin
                  found = 1;
                  x.frame = fap_pkg::FRAME_OUT_W'(i);
                  x.victim = 1'b1;
               end
            if (!found) x.status = fap_pkg::ST_NO_FRAME;
         end
      end else if (r.op == fap_pkg::OP_FREE || r.op == fap_pkg::OP_PIN
                   || r.op == fap_pkg::OP_UNPIN || r.op == fap_pkg::OP_QUERY) begin
         if (int'(r.index) >= active_frames) begin
            x.status = fap_pkg::ST_BAD_INDEX;
         end else begin
            case (r.op)
               fap_pkg::OP_FREE: begin
                  if (frame_owned[r.index]) begin
                     frame_owned[r.index]  = 1'b0;
                     frame_pinned[r.index] = 1'b0;
                     frame_owner[r.index]  = '0;
                     owned_tally--;
                     ring_frames[fap_pkg::FRAME_OUT_W'(ring_head + ring_fill)] =
                        fap_pkg::FRAME_OUT_W'(r.index);
                     ring_fill++;
                  end
               end
               fap_pkg::OP_PIN:   frame_pinned[r.index] = 1'b1;
               fap_pkg::OP_UNPIN: frame_pinned[r.index] = 1'b0;
               default: begin
                  x.frame  = fap_pkg::FRAME_OUT_W'(r.index);
                  x.owned  = frame_owned[r.index];
                  x.pinned = frame_pinned[r.index];
                  x.owner  = frame_owner[r.index];
               end
            endcase
         end
      end
      x.faults = fault_tally;
      x.in_use = owned_tally;
      return x;
   endfunction

   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   task automatic flag_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      end
   endtask

   // sender
   always @(posedge clock) begin : sender
      int           gap_left;
      frame_op_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (op_backlog.size() > 0) begin
            item = op_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= fap_pkg::REQ_DATA_W'({item.index, item.page});
            req_tuser  <= item.op;
            gap_left = pick_gap(send_gap_pct);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver; a hold-off request stalls it for a long fixed stretch
   always @(posedge clock) begin : receiver
      int holds_served;
      int hold_left;
      int stall_left;
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         holds_served = 0;
         hold_left = 0;
         stall_left = 0;
      end else if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         g = pick_gap(stall_pct);
         stall_left = (g > 0) ? g - 1 : 0;
         rsp_tready <= (g == 0);
      end
   end

   // response check, then prediction of the newly accepted operation
   always @(posedge clock) begin : monitor
      frame_reply_type want;
      frame_reply_type got;
      frame_op_type    taken;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = fap_pkg::status_type'(rsp_tdata[1:0]);
            got.frame  = rsp_tdata[7:2];
            got.victim = rsp_tdata[8];
            got.owned  = rsp_tdata[9];
            got.pinned = rsp_tdata[10];
            got.owner  = rsp_tdata[30:11];
            got.faults = rsp_tdata[62:31];
            got.in_use = rsp_tdata[69:63];
            if (due_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected transfer, data 0x%0h", $realtime, rsp_tdata);
            end else begin
               want = due_replies.pop_front();
               flag_field("status", want.status, got.status);
               flag_field("frame_out", want.frame, got.frame);
               flag_field("from_victim", want.victim, got.victim);
               flag_field("entry_allocated", want.owned, got.owned);
               flag_field("entry_pinned", want.pinned, got.pinned);
               flag_field("entry_owner", want.owner, got.owner);
               flag_field("fault_total", want.faults, got.faults);
               flag_field("allocated_total", want.in_use, got.in_use);
            end
         end
         if (req_tvalid && req_tready) begin
            taken.op    = req_tuser;
            taken.page  = req_tdata[19:0];
            taken.index = req_tdata[27:20];
            due_replies.push_back(apply_frame_op(taken));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic add_op(logic [fap_pkg::OPCODE_W-1:0] op, logic [fap_pkg::PAGE_W-1:0] page,
                         logic [fap_pkg::INDEX_W-1:0] index);
      frame_op_type r;
      r.op    = op;
      r.page  = page;
      r.index = index;
      op_backlog.push_back(r);
   endtask

   task automatic add_random_op(int alloc_weight);
      int roll;
      int k;
      logic [fap_pkg::OPCODE_W-1:0] op;
      logic [fap_pkg::INDEX_W-1:0]  index;
      roll = $urandom_range(99);
      if (roll < alloc_weight) begin
         op = fap_pkg::OP_ALLOCATE;
      end else begin
         roll = $urandom_range(99);
         if (roll < 40)      op = fap_pkg::OP_FREE;
         else if (roll < 57) op = fap_pkg::OP_PIN;
         else if (roll < 74) op = fap_pkg::OP_UNPIN;
         else if (roll < 94) op = fap_pkg::OP_QUERY;
         else op = fap_pkg::OPCODE_W'($urandom_range(int'(fap_pkg::OP_QUERY) + 1,
                                                     int'(OPCODE_TOP)));
      end
      k = $urandom_range(19);
      if (k == 0)      index = fap_pkg::INDEX_W'($urandom_range(255));
      else if (k == 1) index = fap_pkg::INDEX_W'($urandom_range(active_frames, 255));
      else             index = fap_pkg::INDEX_W'($urandom_range(active_frames - 1));
      add_op(op, fap_pkg::PAGE_W'($urandom), index);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (op_backlog.size() != 0 || req_tvalid || due_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_frame_count(logic [fap_pkg::FRAME_COUNT_W-1:0] count);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {fap_pkg::REG_FRAME_COUNT, 2'b00};
      csr_pwdata  <= fap_pkg::CSR_DATA_W'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      restart_allocator(count);
      @(negedge clock);
   endtask

   initial begin
      int phase_frames [PHASES] = '{0, 1, 127, 64, 3, 17, 64, 65, 40, 0};
      int phase_alloc  [PHASES] = '{60, 50, 40, 35, 45, 40, 35, 30, 50, 40};
      int phase_gap    [PHASES] = '{20, 30, 0, 25, 50, 10, 0, 20, 30, 20};
      int phase_stall  [PHASES] = '{20, 30, 0, 25, 10, 50, 0, 20, 30, 20};
      int per_phase;
      restart_allocator(fap_pkg::FRAME_COUNT_W'(fap_pkg::FRAME_COUNT_RESET));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default count: table access, invalid indices, unknown opcodes
      send_gap_pct = 20;
      stall_pct    = 20;
      add_op(fap_pkg::OP_QUERY, '0, 8'd0);
      add_op(fap_pkg::OP_ALLOCATE, '1, '1);
      add_op(fap_pkg::OP_ALLOCATE, '0, '0);
      add_op(fap_pkg::OP_QUERY, '0, 8'd0);
      add_op(fap_pkg::OP_PIN, '0, 8'd0);
      add_op(fap_pkg::OP_QUERY, '1, 8'd0);
      add_op(fap_pkg::OP_FREE, '0, 8'd0);
      add_op(fap_pkg::OP_FREE, '0, 8'd0);
      add_op(fap_pkg::OP_PIN, '0, 8'd63);
      add_op(fap_pkg::OP_QUERY, '0, 8'd63);
      add_op(fap_pkg::OP_FREE, '0, 8'd64);
      add_op(fap_pkg::OP_PIN, '0, '1);
      add_op(fap_pkg::OP_QUERY, '0, 8'd64);
      for (int op = int'(fap_pkg::OP_QUERY) + 1; op <= int'(OPCODE_TOP); op++)
         add_op(fap_pkg::OPCODE_W'(op), '1, '1);
      wait_idle();

      // two frames: exhaustion, victim choice, pinning and re-use
      write_frame_count(fap_pkg::FRAME_COUNT_W'(2));
      add_op(fap_pkg::OP_ALLOCATE, 20'h12345, '0);
      add_op(fap_pkg::OP_ALLOCATE, 20'hABCDE, '0);
      add_op(fap_pkg::OP_ALLOCATE, '0, '0);
      add_op(fap_pkg::OP_PIN, '0, 8'd0);
      add_op(fap_pkg::OP_ALLOCATE, '0, '0);
      add_op(fap_pkg::OP_PIN, '0, 8'd1);
      add_op(fap_pkg::OP_ALLOCATE, '0, '0);
      add_op(fap_pkg::OP_UNPIN, '0, 8'd0);
      add_op(fap_pkg::OP_FREE, '0, 8'd1);
      add_op(fap_pkg::OP_ALLOCATE, 20'h55555, '0);
      wait_idle();

      phase_frames[PHASES-1] = $urandom_range(1, 127);
      per_phase = 165;
      for (int p = 0; p < PHASES; p++) begin
         write_frame_count(fap_pkg::FRAME_COUNT_W'(phase_frames[p]));
         send_gap_pct = phase_gap[p];
         stall_pct    = phase_stall[p];
         for (int i = 0; i < per_phase / 2; i++) add_random_op(phase_alloc[p]);
         if (phase_gap[p] == 0 && phase_stall[p] == 0)
            hold_requests <= hold_requests + 1;
         wait_idle();
         for (int i = per_phase / 2; i < per_phase; i++) add_random_op(phase_alloc[p]);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && due_replies.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
sv/fap_pkg.sv
sv/fap_free_queue.sv
sv/fap_owner_ram.sv
sv/frame_allocator_with_pinning.sv
verif/tb_top.sv
